// File: hw/rtl/x86d_pkg.sv
// Package with the word types, stage types, codes and helpers of the x86 decoder.
package x86d_pkg;

    // Input word: one six-byte code window and the address of its first byte.
    typedef struct packed {
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic [7:0]  byte3;
        logic [7:0]  byte4;
        logic [7:0]  byte5;
        logic [15:0] instr_address;
    } in_word_t;

    // Output word: one decoded instruction.
    typedef struct packed {
        logic               valid_res;
        logic [2:0]         mnemonic;
        logic [2:0]         form;
        logic               wide;
        logic               reg_is_dest;
        logic [1:0]         mode;
        logic [2:0]         reg_field;
        logic [2:0]         rm_field;
        logic signed [15:0] displacement;
        logic [15:0]        immediate;
        logic [15:0]        jump_target;
        logic [2:0]         length;
    } out_word_t;

    // Mnemonic codes.
    localparam logic [2:0] MN_MOV = 3'd0;
    localparam logic [2:0] MN_ADD = 3'd1;
    localparam logic [2:0] MN_SUB = 3'd2;
    localparam logic [2:0] MN_CMP = 3'd3;
    localparam logic [2:0] MN_JNZ = 3'd4;

    // Operand form codes.
    localparam logic [2:0] FORM_REG_RM  = 3'd0;
    localparam logic [2:0] FORM_IMM_RM  = 3'd1;
    localparam logic [2:0] FORM_IMM_REG = 3'd2;
    localparam logic [2:0] FORM_IMM_ACC = 3'd3;
    localparam logic [2:0] FORM_MEM_ACC = 3'd4;
    localparam logic [2:0] FORM_ACC_MEM = 3'd5;
    localparam logic [2:0] FORM_JUMP    = 3'd6;

    // Opcode patterns, compared against the upper bits of the opcode byte (the whole byte for JNZ).
    localparam logic [5:0] OP6_ADD_RM     = 6'b000000;
    localparam logic [5:0] OP6_SUB_RM     = 6'b001010;
    localparam logic [5:0] OP6_CMP_RM     = 6'b001110;
    localparam logic [5:0] OP6_MOV_RM     = 6'b100010;
    localparam logic [5:0] OP6_GRP_IMM    = 6'b100000;
    localparam logic [6:0] OP7_ADD_ACC    = 7'b0000010;
    localparam logic [6:0] OP7_SUB_ACC    = 7'b0010110;
    localparam logic [6:0] OP7_CMP_ACC    = 7'b0011110;
    localparam logic [6:0] OP7_MOV_IRM    = 7'b1100011;
    localparam logic [6:0] OP7_MOV_MEMACC = 7'b1010000;
    localparam logic [6:0] OP7_MOV_ACCMEM = 7'b1010001;
    localparam logic [3:0] OP4_MOV_IREG   = 4'b1011;
    localparam logic [7:0] OP_JNZ         = 8'h75;

    // Operation selected by the reg field of the immediate group.
    localparam logic [2:0] GRP_ADD = 3'd0;
    localparam logic [2:0] GRP_SUB = 3'd5;
    localparam logic [2:0] GRP_CMP = 3'd7;

    // ModRM mod and rm codes.
    localparam logic [1:0] MOD_NO_DISP = 2'd0;
    localparam logic [1:0] MOD_DISP8   = 2'd1;
    localparam logic [1:0] MOD_DISP16  = 2'd2;
    localparam logic [1:0] MOD_REG     = 2'd3;
    localparam logic [2:0] RM_DIRECT   = 3'd6;

    // Instruction lengths in bytes.
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

    // Result of the classify stage.
    typedef struct packed {
        logic       valid_res;
        logic [2:0] mnemonic;
        logic [2:0] form;
        in_word_t   win;
    } cls_t;

    // Result of the field stage.
    typedef struct packed {
        logic               valid_res;
        logic [2:0]         mnemonic;
        logic [2:0]         form;
        logic               wide;
        logic               reg_is_dest;
        logic [1:0]         mode;
        logic [2:0]         reg_field;
        logic [2:0]         rm_field;
        logic signed [15:0] displacement;
        logic [2:0]         modrm_len;
        logic               sbit;
        logic [15:0]        target_base;
        in_word_t           win;
    } fld_t;

    // Sign-extend a byte to 16 bits.
    function automatic logic [15:0] sx8(input logic [7:0] v);
        return {{8{v[7]}}, v};
    endfunction

endpackage

// File: hw/rtl/x86d_classify.sv
// First decoder stage: classifies the opcode into mnemonic and operand form.
module x86d_classify (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  x86d_pkg::in_word_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output x86d_pkg::cls_t    out_data
);
    import x86d_pkg::*;

    logic       valid_reg;
    cls_t       data_reg;
    cls_t       data_next;
    logic [7:0] op;
    logic [2:0] mreg;

    assign op   = in_data.byte0;
    assign mreg = in_data.byte1[5:3];

    // Priority decode of the opcode, the immediate group split by the reg field.
    always_comb begin
        data_next           = '0;
        data_next.win       = in_data;
        data_next.valid_res = 1'b1;
        if (op[7:2] == OP6_ADD_RM) begin
            data_next.mnemonic = MN_ADD;
            data_next.form     = FORM_REG_RM;
        end else if (op[7:2] == OP6_GRP_IMM && mreg == GRP_ADD) begin
            data_next.mnemonic = MN_ADD;
            data_next.form     = FORM_IMM_RM;
        end else if (op[7:1] == OP7_ADD_ACC) begin
            data_next.mnemonic = MN_ADD;
            data_next.form     = FORM_IMM_ACC;
        end else if (op[7:2] == OP6_SUB_RM) begin
            data_next.mnemonic = MN_SUB;
            data_next.form     = FORM_REG_RM;
        end else if (op[7:2] == OP6_GRP_IMM && mreg == GRP_SUB) begin
            data_next.mnemonic = MN_SUB;
            data_next.form     = FORM_IMM_RM;
        end else if (op[7:1] == OP7_SUB_ACC) begin
            data_next.mnemonic = MN_SUB;
            data_next.form     = FORM_IMM_ACC;
        end else if (op[7:2] == OP6_CMP_RM) begin
            data_next.mnemonic = MN_CMP;
            data_next.form     = FORM_REG_RM;
        end else if (op[7:2] == OP6_GRP_IMM && mreg == GRP_CMP) begin
            data_next.mnemonic = MN_CMP;
            data_next.form     = FORM_IMM_RM;
        end else if (op[7:1] == OP7_CMP_ACC) begin
            data_next.mnemonic = MN_CMP;
            data_next.form     = FORM_IMM_ACC;
        end else if (op[7:2] == OP6_MOV_RM) begin
            data_next.mnemonic = MN_MOV;
            data_next.form     = FORM_REG_RM;
        end else if (op[7:4] == OP4_MOV_IREG) begin
            data_next.mnemonic = MN_MOV;
            data_next.form     = FORM_IMM_REG;
        end else if (op[7:1] == OP7_MOV_IRM) begin
            data_next.mnemonic = MN_MOV;
            data_next.form     = FORM_IMM_RM;
        end else if (op[7:1] == OP7_MOV_MEMACC) begin
            data_next.mnemonic = MN_MOV;
            data_next.form     = FORM_MEM_ACC;
        end else if (op[7:1] == OP7_MOV_ACCMEM) begin
            data_next.mnemonic = MN_MOV;
            data_next.form     = FORM_ACC_MEM;
        end else if (op == OP_JNZ) begin
            data_next.mnemonic = MN_JNZ;
            data_next.form     = FORM_JUMP;
        end else begin
            data_next.valid_res = 1'b0;
        end
    end

    // The stage takes a word when it is empty or its word moves on.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

// File: hw/rtl/x86d_fields.sv
// Second decoder stage: extracts width, direction, ModRM fields and displacement.
module x86d_fields (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  x86d_pkg::cls_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output x86d_pkg::fld_t out_data
);
    import x86d_pkg::*;

    logic       valid_reg;
    fld_t       data_reg;
    fld_t       data_next;
    logic [7:0] op;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;

    assign op = in_data.win.byte0;
    assign b1 = in_data.win.byte1;
    assign b2 = in_data.win.byte2;
    assign b3 = in_data.win.byte3;

    // Field extraction per form; an unrecognized opcode leaves width, direction, ModRM fields and displacement zero.
    always_comb begin
        data_next             = '0;
        data_next.valid_res   = in_data.valid_res;
        data_next.mnemonic    = in_data.mnemonic;
        data_next.form        = in_data.form;
        data_next.modrm_len   = LEN_TWO;
        data_next.target_base = in_data.win.instr_address + 16'd2;
        data_next.win         = in_data.win;
        if (in_data.valid_res) begin
            unique case (in_data.form) inside
                FORM_REG_RM, FORM_IMM_RM: begin
                    data_next.wide        = op[0];
                    data_next.mode        = b1[7:6];
                    data_next.reg_field   = b1[5:3];
                    data_next.rm_field    = b1[2:0];
                    data_next.reg_is_dest = (in_data.form == FORM_REG_RM) ? op[1] : 1'b0;
                    data_next.sbit        = (in_data.form == FORM_IMM_RM)
                                            && (op[7:2] == OP6_GRP_IMM) && op[1];
                    unique case (b1[7:6])
                        MOD_NO_DISP: begin
                            if (b1[2:0] == RM_DIRECT) begin
                                data_next.displacement = {b3, b2};
                                data_next.modrm_len    = LEN_FOUR;
                            end
                        end
                        MOD_DISP8: begin
                            data_next.displacement = sx8(b2);
                            data_next.modrm_len    = LEN_THREE;
                        end
                        MOD_DISP16: begin
                            data_next.displacement = {b3, b2};
                            data_next.modrm_len    = LEN_FOUR;
                        end
                        MOD_REG: begin
                            data_next.modrm_len = LEN_TWO;
                        end
                    endcase
                end
                FORM_IMM_REG: begin
                    data_next.wide        = op[3];
                    data_next.reg_is_dest = 1'b1;
                    data_next.reg_field   = op[2:0];
                end
                FORM_IMM_ACC, FORM_MEM_ACC: begin
                    data_next.wide        = op[0];
                    data_next.reg_is_dest = 1'b1;
                    if (in_data.form == FORM_MEM_ACC) begin
                        data_next.displacement = {b2, b1};
                    end
                end
                FORM_ACC_MEM: begin
                    data_next.wide         = op[0];
                    data_next.displacement = {b2, b1};
                end
                FORM_JUMP: begin
                    data_next.displacement = sx8(b1);
                end
                default: begin
                    data_next.modrm_len = LEN_TWO;
                end
            endcase
        end
    end

    // The stage takes a word when it is empty or its word moves on.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

// File: hw/rtl/x86d_finish.sv
// Third decoder stage: selects the immediate, sets the length and the jump target.
module x86d_finish (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  x86d_pkg::fld_t      in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output x86d_pkg::out_word_t out_data
);
    import x86d_pkg::*;

    logic       valid_reg;
    out_word_t  data_reg;
    out_word_t  data_next;
    logic [7:0] imm_lo;
    logic [7:0] imm_hi;

    // Bytes that follow the ModRM part, for the immediate of the r/m form.
    always_comb begin
        case (in_data.modrm_len)
            LEN_TWO: begin
                imm_lo = in_data.win.byte2;
                imm_hi = in_data.win.byte3;
            end
            LEN_THREE: begin
                imm_lo = in_data.win.byte3;
                imm_hi = in_data.win.byte4;
            end
            default: begin
                imm_lo = in_data.win.byte4;
                imm_hi = in_data.win.byte5;
            end
        endcase
    end

    // Immediate, length and jump target per form.
    always_comb begin
        data_next              = '0;
        data_next.valid_res    = in_data.valid_res;
        data_next.mnemonic     = in_data.mnemonic;
        data_next.form         = in_data.form;
        data_next.wide         = in_data.wide;
        data_next.reg_is_dest  = in_data.reg_is_dest;
        data_next.mode         = in_data.mode;
        data_next.reg_field    = in_data.reg_field;
        data_next.rm_field     = in_data.rm_field;
        data_next.displacement = in_data.displacement;
        data_next.length       = LEN_TWO;
        if (in_data.valid_res) begin
            unique case (in_data.form) inside
                FORM_REG_RM: begin
                    data_next.length = in_data.modrm_len;
                end
                FORM_IMM_RM: begin
                    if (in_data.wide && !in_data.sbit) begin
                        data_next.immediate = {imm_hi, imm_lo};
                        data_next.length    = in_data.modrm_len + 3'd2;
                    end else begin
                        data_next.immediate = in_data.sbit ? sx8(imm_lo) : {8'h00, imm_lo};
                        data_next.length    = in_data.modrm_len + 3'd1;
                    end
                end
                FORM_IMM_REG, FORM_IMM_ACC: begin
                    if (in_data.wide) begin
                        data_next.immediate = {in_data.win.byte2, in_data.win.byte1};
                        data_next.length    = LEN_THREE;
                    end else begin
                        data_next.immediate = {8'h00, in_data.win.byte1};
                        data_next.length    = LEN_TWO;
                    end
                end
                FORM_MEM_ACC, FORM_ACC_MEM: begin
                    data_next.length = LEN_THREE;
                end
                FORM_JUMP: begin
                    data_next.jump_target = in_data.target_base
                                            + $unsigned(in_data.displacement);
                    data_next.length      = LEN_TWO;
                end
                default: begin
                    data_next.length = LEN_TWO;
                end
            endcase
        end
    end

    // The output register takes a word when it is empty or its word is taken.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

// File: hw/rtl/x86_16bit_instruction_decoder.sv
// Top level of the 16-bit x86 instruction decoder: three-stage decode pipeline.
//
//   Channel   Ports                      Word
//   input     s_valid s_ready s_data     six code bytes and the instruction address
//   output    m_valid m_ready m_data     one decoded instruction
//
// One word enters per cycle while m_ready does not stall the pipeline; an accepted word
// passes through the classify, field and output registers in turn before it can leave
// (classify, field extraction, immediate and length).
// Reset clears the valid bit of every stage; data registers are not reset.
// Each stage holds its word while the stage after it is full and stalled, so
// a stall on m_ready backs up stage by stage and nothing is lost or repeated.
module x86_16bit_instruction_decoder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  x86d_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output x86d_pkg::out_word_t m_data
);
    import x86d_pkg::*;

    logic cls_valid;
    logic cls_ready;
    cls_t cls_data;
    logic fld_valid;
    logic fld_ready;
    fld_t fld_data;

    // Stage one: opcode classification.
    x86d_classify u_classify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (cls_valid),
        .out_ready (cls_ready),
        .out_data  (cls_data)
    );

    // Stage two: ModRM fields and displacement.
    x86d_fields u_fields (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cls_valid),
        .in_ready  (cls_ready),
        .in_data   (cls_data),
        .out_valid (fld_valid),
        .out_ready (fld_ready),
        .out_data  (fld_data)
    );

    // Stage three: immediate, length and jump target into the output register.
    x86d_finish u_finish (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fld_valid),
        .in_ready  (fld_ready),
        .in_data   (fld_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

// File: verif/x86_16bit_instruction_decoder_tb.sv
// Self-checking testbench for the 16-bit x86 instruction decoder with a built-in decode predictor.
module x86_16bit_instruction_decoder_tb;
    import x86d_pkg::*;

    localparam int RANDOM_WORDS = 1280;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 8;

    // Opcodes that fall outside the decoded subset.
    localparam logic [7:0] OP_MOV_SEG = 8'h8C;
    localparam logic [7:0] OP_HLT     = 8'hF4;
    localparam logic [7:0] OP_JZ      = 8'h74;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    out_word_t expected_decodes[$];
    out_word_t oldest_decode;
    int        fail_count = 0;
    int        burst_left = 0;

    logic [5:0]  stall_phase = '0;
    logic [15:0] stall_mask  = '1;

    x86_16bit_instruction_decoder uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Free-running clock, period 20.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Predict the decoded word for one code window.
    function automatic out_word_t decode_window(in_word_t w);
        logic [7:0]  b [6];
        logic [2:0]  mreg;
        logic        regmem;
        logic        immrm;
        logic        immacc;
        logic        sbit;
        logic [2:0]  p;
        logic [15:0] word12;
        logic [15:0] word23;
        logic [15:0] rel8;
        out_word_t   r;
        b[0] = w.byte0;
        b[1] = w.byte1;
        b[2] = w.byte2;
        b[3] = w.byte3;
        b[4] = w.byte4;
        b[5] = w.byte5;
        mreg = b[1][5:3];
        word12 = {b[2], b[1]};
        word23 = {b[3], b[2]};
        regmem = 1'b0;
        immrm = 1'b0;
        immacc = 1'b0;
        r = '0;
        r.valid_res = 1'b1;
        r.length = LEN_TWO;

        // Classify by opcode, in priority order.
        if (b[0][7:2] == OP6_ADD_RM) begin
            r.mnemonic = MN_ADD; regmem = 1'b1;
        end else if (b[0][7:2] == OP6_GRP_IMM && mreg == GRP_ADD) begin
            r.mnemonic = MN_ADD; immrm = 1'b1;
        end else if (b[0][7:1] == OP7_ADD_ACC) begin
            r.mnemonic = MN_ADD; immacc = 1'b1;
        end else if (b[0][7:2] == OP6_SUB_RM) begin
            r.mnemonic = MN_SUB; regmem = 1'b1;
        end else if (b[0][7:2] == OP6_GRP_IMM && mreg == GRP_SUB) begin
            r.mnemonic = MN_SUB; immrm = 1'b1;
        end else if (b[0][7:1] == OP7_SUB_ACC) begin
            r.mnemonic = MN_SUB; immacc = 1'b1;
        end else if (b[0][7:2] == OP6_CMP_RM) begin
            r.mnemonic = MN_CMP; regmem = 1'b1;
        end else if (b[0][7:2] == OP6_GRP_IMM && mreg == GRP_CMP) begin
            r.mnemonic = MN_CMP; immrm = 1'b1;
        end else if (b[0][7:1] == OP7_CMP_ACC) begin
            r.mnemonic = MN_CMP; immacc = 1'b1;
        end else if (b[0][7:2] == OP6_MOV_RM) begin
            r.mnemonic = MN_MOV; regmem = 1'b1;
        end else if (b[0][7:4] == OP4_MOV_IREG) begin
            r.form = FORM_IMM_REG;
            r.wide = b[0][3];
            r.reg_is_dest = 1'b1;
            r.reg_field = b[0][2:0];
            r.immediate = r.wide ? word12 : {8'h00, b[1]};
            r.length = r.wide ? LEN_THREE : LEN_TWO;
        end else if (b[0][7:1] == OP7_MOV_IRM) begin
            r.mnemonic = MN_MOV; immrm = 1'b1;
        end else if (b[0][7:1] == OP7_MOV_MEMACC || b[0][7:1] == OP7_MOV_ACCMEM) begin
            r.form = (b[0][7:1] == OP7_MOV_MEMACC) ? FORM_MEM_ACC : FORM_ACC_MEM;
            r.wide = b[0][0];
            r.reg_is_dest = (b[0][7:1] == OP7_MOV_MEMACC);
            r.displacement = word12;
            r.length = LEN_THREE;
        end else if (b[0] == OP_JNZ) begin
            rel8 = {{8{b[1][7]}}, b[1]};
            r.mnemonic = MN_JNZ;
            r.form = FORM_JUMP;
            r.displacement = rel8;
            r.jump_target = w.instr_address + 16'd2 + rel8;
        end else begin
            r.valid_res = 1'b0;
        end

        // ModRM, displacement and the immediate that follows them.
        if (regmem || immrm) begin
            r.wide = b[0][0];
            r.mode = b[1][7:6];
            r.reg_field = mreg;
            r.rm_field = b[1][2:0];
            case (r.mode)
                MOD_NO_DISP: begin
                    if (r.rm_field == RM_DIRECT) begin
                        r.displacement = word23;
                        r.length = LEN_FOUR;
                    end
                end
                MOD_DISP8: begin
                    r.displacement = {{8{b[2][7]}}, b[2]};
                    r.length = LEN_THREE;
                end
                MOD_DISP16: begin
                    r.displacement = word23;
                    r.length = LEN_FOUR;
                end
                default: r.length = LEN_TWO;
            endcase
            if (regmem) begin
                r.form = FORM_REG_RM;
                r.reg_is_dest = b[0][1];
            end else begin
                p = r.length;
                sbit = (b[0][7:2] == OP6_GRP_IMM) && b[0][1];
                r.form = FORM_IMM_RM;
                if (r.wide && !sbit) begin
                    r.immediate = {b[p + 3'd1], b[p]};
                    r.length = p + 3'd2;
                end else begin
                    r.immediate = sbit ? {{8{b[p][7]}}, b[p]} : {8'h00, b[p]};
                    r.length = p + 3'd1;
                end
            end
        end

        // Immediate to accumulator.
        if (immacc) begin
            r.form = FORM_IMM_ACC;
            r.wide = b[0][0];
            r.reg_is_dest = 1'b1;
            r.immediate = r.wide ? word12 : {8'h00, b[1]};
            r.length = r.wide ? LEN_THREE : LEN_TWO;
        end
        return r;
    endfunction

    function automatic in_word_t make_window(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                             logic [7:0] b3, logic [7:0] b4, logic [7:0] b5,
                                             logic [15:0] addr);
        in_word_t w;
        w.byte0 = b0;
        w.byte1 = b1;
        w.byte2 = b2;
        w.byte3 = b3;
        w.byte4 = b4;
        w.byte5 = b5;
        w.instr_address = addr;
        return w;
    endfunction

    // Build a mostly well-formed window: a decodable opcode with random operand bytes.
    function automatic in_word_t random_window();
        logic [5:0] rm_ops  [4];
        logic [6:0] acc_ops [3];
        logic [2:0] grp_ops [3];
        in_word_t   w;
        rm_ops  = '{OP6_ADD_RM, OP6_SUB_RM, OP6_CMP_RM, OP6_MOV_RM};
        acc_ops = '{OP7_ADD_ACC, OP7_SUB_ACC, OP7_CMP_ACC};
        grp_ops = '{GRP_ADD, GRP_SUB, GRP_CMP};
        w = in_word_t'({$urandom, $urandom});
        if ($urandom_range(0, 7) == 0)
            w.byte1[2:0] = RM_DIRECT;
        if ($urandom_range(0, 7) == 0)
            w.instr_address = 16'($urandom_range(16'hFF00, 16'hFFFF));
        case ($urandom_range(0, 9))
            0, 1: w.byte0 = {rm_ops[2'($urandom_range(0, 3))], 2'($urandom)};
            2, 3: begin
                w.byte0 = {OP6_GRP_IMM, 2'($urandom)};
                if ($urandom_range(0, 3) != 0)
                    w.byte1[5:3] = grp_ops[2'($urandom_range(0, 2))];
            end
            4: w.byte0 = {acc_ops[2'($urandom_range(0, 2))], 1'($urandom)};
            5: w.byte0 = {OP4_MOV_IREG, 4'($urandom)};
            6: w.byte0 = {OP7_MOV_IRM, 1'($urandom)};
            7: w.byte0 = {($urandom_range(0, 1) != 0) ? OP7_MOV_MEMACC : OP7_MOV_ACCMEM,
                          1'($urandom)};
            8: w.byte0 = OP_JNZ;
            default: ;
        endcase
        return w;
    endfunction

    // Present one word in a burst pattern and log its predicted decode on acceptance.
    task automatic send_word(in_word_t w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                      : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= w;
        do @(negedge aclk); while (!s_ready);
        expected_decodes.push_back(decode_window(w));
        @(posedge aclk);
    endtask

    // Receiver stalls follow a 16-bit mask, indexed by a phase counter and redrawn each time it wraps.
    always @(posedge aclk) begin
        stall_phase <= stall_phase + 6'd1;
        if (stall_phase == 6'd63) begin
            case ($urandom_range(0, 7))
                0, 1: stall_mask <= '1;
                2: stall_mask <= '0;
                default: stall_mask <= 16'($urandom);
            endcase
        end
        m_ready <= stall_mask[stall_phase[3:0]];
    end

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Compare each accepted output word with the oldest prediction.
    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_decodes.size() == 0) begin
                $error("output word 0x%0h arrived with no prediction pending", m_data);
                fail_count++;
            end else begin
                oldest_decode = expected_decodes.pop_front();
                check_field("valid_res", oldest_decode.valid_res, m_data.valid_res);
                check_field("mnemonic", oldest_decode.mnemonic, m_data.mnemonic);
                check_field("form", oldest_decode.form, m_data.form);
                check_field("wide", oldest_decode.wide, m_data.wide);
                check_field("reg_is_dest", oldest_decode.reg_is_dest, m_data.reg_is_dest);
                check_field("mode", oldest_decode.mode, m_data.mode);
                check_field("reg_field", oldest_decode.reg_field, m_data.reg_field);
                check_field("rm_field", oldest_decode.rm_field, m_data.rm_field);
                check_field("displacement", oldest_decode.displacement, m_data.displacement);
                check_field("immediate", oldest_decode.immediate, m_data.immediate);
                check_field("jump_target", oldest_decode.jump_target, m_data.jump_target);
                check_field("length", oldest_decode.length, m_data.length);
            end
        end
    end

    // Register/memory forms: every mod, the direct address case, both d and w.
    task automatic test_reg_rm_forms();
        send_word(make_window({OP6_ADD_RM, 2'b00}, {MOD_REG, 3'd0, 3'd0},
                              8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
        send_word(make_window({OP6_SUB_RM, 2'b11}, {MOD_NO_DISP, 3'd7, RM_DIRECT},
                              8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
        send_word(make_window({OP6_CMP_RM, 2'b10}, {MOD_DISP8, 3'd3, 3'd1},
                              8'h80, 8'h55, 8'hAA, 8'h01, 16'h1000));
        send_word(make_window({OP6_MOV_RM, 2'b01}, {MOD_DISP16, 3'd5, 3'd7},
                              8'h34, 8'h12, 8'h00, 8'hFF, 16'h8000));
        send_word(make_window({OP6_ADD_RM, 2'b11}, {MOD_NO_DISP, 3'd2, 3'd4},
                              8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'h7FFF));
    endtask

    // Immediate to r/m: s bit, immediate after disp8, and an undefined group operation.
    task automatic test_imm_rm_forms();
        send_word(make_window({OP6_GRP_IMM, 2'b00}, {MOD_REG, GRP_ADD, 3'd0},
                              8'h7F, 8'h00, 8'h00, 8'h00, 16'h0002));
        send_word(make_window({OP6_GRP_IMM, 2'b01}, {MOD_DISP16, GRP_SUB, 3'd2},
                              8'h00, 8'h80, 8'hCD, 8'hAB, 16'h0100));
        send_word(make_window({OP6_GRP_IMM, 2'b11}, {MOD_DISP8, GRP_CMP, 3'd6},
                              8'hF0, 8'h80, 8'h11, 8'h22, 16'h0200));
        send_word(make_window({OP6_GRP_IMM, 2'b10}, {MOD_NO_DISP, GRP_ADD, RM_DIRECT},
                              8'h00, 8'h10, 8'hFE, 8'h33, 16'h0300));
        send_word(make_window({OP6_GRP_IMM, 2'b01}, {MOD_REG, 3'd3, 3'd1},
                              8'h12, 8'h34, 8'h56, 8'h78, 16'h0400));
        send_word(make_window({OP7_MOV_IRM, 1'b1}, {MOD_DISP8, 3'd0, 3'd3},
                              8'h7F, 8'hEF, 8'hBE, 8'h99, 16'h0500));
        send_word(make_window({OP7_MOV_IRM, 1'b0}, {MOD_NO_DISP, 3'd6, RM_DIRECT},
                              8'h00, 8'h20, 8'hFF, 8'h00, 16'h0600));
    endtask

    // Accumulator and register immediates, and the direct memory moves.
    task automatic test_acc_reg_forms();
        send_word(make_window({OP7_ADD_ACC, 1'b0}, 8'hFF, 8'h12, 8'h00, 8'h00, 8'h00, 16'h0010));
        send_word(make_window({OP7_SUB_ACC, 1'b1}, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 16'h0020));
        send_word(make_window({OP7_CMP_ACC, 1'b1}, 8'h01, 8'h80, 8'hFF, 8'hFF, 8'hFF, 16'h0030));
        send_word(make_window({OP4_MOV_IREG, 1'b1, 3'd7}, 8'h34, 8'h12, 8'h00, 8'h00, 8'h00,
                              16'h0040));
        send_word(make_window({OP4_MOV_IREG, 1'b0, 3'd0}, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                              16'h0050));
        send_word(make_window({OP7_MOV_MEMACC, 1'b1}, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'hFF,
                              16'h0060));
        send_word(make_window({OP7_MOV_ACCMEM, 1'b0}, 8'hFF, 8'h7F, 8'h00, 8'h00, 8'h00,
                              16'h0070));
    endtask

    // Branch targets, including wraparound in both directions.
    task automatic test_jnz_targets();
        send_word(make_window(OP_JNZ, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 16'hFFFF));
        send_word(make_window(OP_JNZ, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'h0000));
        send_word(make_window(OP_JNZ, 8'hFE, 8'h00, 8'h00, 8'h00, 8'h00, 16'h1234));
    endtask

    // Opcodes outside the decoded subset.
    task automatic test_undefined_opcodes();
        send_word(make_window(OP_MOV_SEG, 8'hC0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0080));
        send_word(make_window(OP_HLT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
        send_word(make_window(OP_JZ, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0090));
    endtask

    // Random windows, mostly decodable opcodes with some raw byte noise.
    task automatic test_random_windows();
        in_word_t w;
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if ($urandom_range(0, 6) == 0)
                w = in_word_t'({$urandom, $urandom});
            else
                w = random_window();
            send_word(w);
        end
    endtask

    // Wait for every prediction to be matched, then give the verdict.
    task automatic drain_and_report();
        int cycles;
        cycles = 0;
        s_valid <= 1'b0;
        while (expected_decodes.size() != 0 && cycles < DRAIN_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        if (expected_decodes.size() != 0) begin
            $error("%0d predicted words never came out", expected_decodes.size());
            fail_count += expected_decodes.size();
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("x86_16bit_instruction_decoder verification clean");
        else
            $display("x86_16bit_instruction_decoder verification failed");
        $finish;
    endtask

    // Test sequence.
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_reg_rm_forms();
        test_imm_rm_forms();
        test_acc_reg_forms();
        test_jnz_targets();
        test_undefined_opcodes();
        test_random_windows();
        drain_and_report();
    end

    // Watchdog against a hung handshake.
    initial begin
        #10000000;
        $display("x86_16bit_instruction_decoder verification failed");
        $finish;
    end

endmodule
